>>> hw/rtl/pfd_pkg.sv
// Shared types and constants for the payload frame deframer.
// No dependencies; imported by pfd_parse and payload_frame_deframer.

package pfd_pkg;

  // Byte positions within the 11-byte header
  localparam logic [15:0] HDR_START    = 16'd0;
  localparam logic [15:0] HDR_SIZE_LO  = 16'd1;
  localparam logic [15:0] HDR_SIZE_HI  = 16'd2;
  localparam logic [15:0] HDR_DEST_HI  = 16'd3;
  localparam logic [15:0] HDR_DEST_LO  = 16'd4;
  localparam logic [15:0] HDR_ORIG_HI  = 16'd5;
  localparam logic [15:0] HDR_ORIG_LO  = 16'd6;
  localparam logic [15:0] HDR_TXID_HI  = 16'd7;
  localparam logic [15:0] HDR_TXID_LO  = 16'd8;
  localparam logic [15:0] HDR_TYPE_HI  = 16'd9;
  localparam logic [15:0] HDR_LAST     = 16'd10;

  // Non-payload bytes counted in the size field
  localparam logic [15:0] SIZE_OVERHEAD = 16'd12;

  localparam logic [7:0] START_BYTE_RESET = 8'd0;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_CRC     = 2'd2,
    PH_SPARE   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_COMPLETE  = 2'd1,
    KIND_BAD_START = 2'd2,
    KIND_LEN_ERROR = 2'd3
  } kind_t;

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [15:0] frame_size;
    logic [15:0] destination;
    logic [15:0] origin;
    logic [15:0] transaction_id;
    logic [15:0] message_type;
    logic [15:0] crc_value;
    logic        last;
  } result_t;

endpackage

>>> hw/rtl/pfd_parse.sv
// Frame parser: phase state machine, header field capture and result build.
// Depends on pfd_pkg. The result is combinational from the current beat.

module pfd_parse (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  input  logic [7:0]       start_byte,
  output pfd_pkg::result_t res
);
  import pfd_pkg::*;

  phase_t      phase, phase_next;
  logic [15:0] byte_count, byte_count_next;
  logic        start_ok, start_ok_next;
  logic [15:0] size_reg, size_reg_next;
  logic [15:0] dest_reg, dest_reg_next;
  logic [15:0] origin_reg, origin_reg_next;
  logic [15:0] txid_reg, txid_reg_next;
  logic [15:0] type_reg, type_reg_next;
  logic [15:0] crc_reg, crc_reg_next;

  logic        hdr_done;
  logic        payload_end;
  logic [16:0] payload_len;

  assign hdr_done    = (byte_count == HDR_LAST);
  assign payload_len = {1'b0, size_reg} - {1'b0, SIZE_OVERHEAD};
  assign payload_end = ({1'b0, byte_count} + 17'd1) >= payload_len;

  // Next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_PAYLOAD: begin
        if (payload_end) phase_next = PH_CRC;
      end
      PH_CRC: begin
        if (byte_count != 16'd0) phase_next = PH_HEADER;
      end
      default: begin
        phase_next = PH_HEADER;
        if (hdr_done && start_ok && (size_reg == SIZE_OVERHEAD)) begin
          phase_next = PH_CRC;
        end else if (hdr_done && start_ok && (size_reg > SIZE_OVERHEAD)) begin
          phase_next = PH_PAYLOAD;
        end
      end
    endcase
  end

  // Field capture, counter and result
  always_comb begin
    byte_count_next = byte_count;
    start_ok_next   = start_ok;
    size_reg_next   = size_reg;
    dest_reg_next   = dest_reg;
    origin_reg_next = origin_reg;
    txid_reg_next   = txid_reg;
    type_reg_next   = type_reg;
    crc_reg_next    = crc_reg;
    res             = '0;
    res.kind        = KIND_PAYLOAD;
    case (phase)
      PH_PAYLOAD: begin
        res.valid         = 1'b1;
        res.payload_byte  = rx_byte;
        res.payload_index = byte_count;
        byte_count_next   = payload_end ? 16'd0 : byte_count + 16'd1;
      end
      PH_CRC: begin
        if (byte_count == 16'd0) begin
          crc_reg_next    = {rx_byte, crc_reg[7:0]};
          byte_count_next = 16'd1;
        end else begin
          crc_reg_next       = {crc_reg[15:8], rx_byte};
          byte_count_next    = 16'd0;
          res.valid          = 1'b1;
          res.kind           = KIND_COMPLETE;
          res.frame_size     = size_reg;
          res.destination    = dest_reg;
          res.origin         = origin_reg;
          res.transaction_id = txid_reg;
          res.message_type   = type_reg;
          res.crc_value      = {crc_reg[15:8], rx_byte};
          res.last           = 1'b1;
        end
      end
      default: begin
        // Capture the header byte at its position
        case (byte_count)
          HDR_START:   start_ok_next   = (rx_byte == start_byte);
          HDR_SIZE_LO: size_reg_next   = {size_reg[15:8], rx_byte};
          HDR_SIZE_HI: size_reg_next   = {rx_byte, size_reg[7:0]};
          HDR_DEST_HI: dest_reg_next   = {rx_byte, dest_reg[7:0]};
          HDR_DEST_LO: dest_reg_next   = {dest_reg[15:8], rx_byte};
          HDR_ORIG_HI: origin_reg_next = {rx_byte, origin_reg[7:0]};
          HDR_ORIG_LO: origin_reg_next = {origin_reg[15:8], rx_byte};
          HDR_TXID_HI: txid_reg_next   = {rx_byte, txid_reg[7:0]};
          HDR_TXID_LO: txid_reg_next   = {txid_reg[15:8], rx_byte};
          HDR_TYPE_HI: type_reg_next   = {rx_byte, type_reg[7:0]};
          default:     type_reg_next   = {type_reg[15:8], rx_byte};
        endcase
        if (byte_count < HDR_LAST) begin
          byte_count_next = byte_count + 16'd1;
        end else begin
          byte_count_next = 16'd0;
          // Reject on bad start, flag a size too short for the non-payload overhead
          if (!start_ok || (size_reg < SIZE_OVERHEAD)) begin
            res.valid          = 1'b1;
            res.kind           = start_ok ? KIND_LEN_ERROR : KIND_BAD_START;
            res.frame_size     = size_reg;
            res.destination    = dest_reg;
            res.origin         = origin_reg;
            res.transaction_id = txid_reg;
            res.message_type   = type_reg_next;
            res.last           = 1'b1;
          end
        end
      end
    endcase
  end

  // Advance state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEADER;
      byte_count <= '0;
      start_ok   <= 1'b0;
      size_reg   <= '0;
      dest_reg   <= '0;
      origin_reg <= '0;
      txid_reg   <= '0;
      type_reg   <= '0;
      crc_reg    <= '0;
    end else if (step) begin
      phase      <= phase_next;
      byte_count <= byte_count_next;
      start_ok   <= start_ok_next;
      size_reg   <= size_reg_next;
      dest_reg   <= dest_reg_next;
      origin_reg <= origin_reg_next;
      txid_reg   <= txid_reg_next;
      type_reg   <= type_reg_next;
      crc_reg    <= crc_reg_next;
    end
  end

endmodule

>>> hw/rtl/payload_frame_deframer.sv
// Top level of the payload frame deframer: config register and output register.
// Depends on pfd_pkg and pfd_parse.
//
// Usage:
//   Input channel in_valid/in_ready carries one received byte (rx_byte) per
//   beat. Output channel out_valid/out_ready carries result records: one per
//   payload byte (with its index), one frame-complete record after the CRC
//   carrying header fields and CRC, or a reject / length-error record after
//   the 11th header byte. Frame-ending records have last set.
//   The expected start byte is written through cfg_we/cfg_wdata while idle.
//   A result is registered and appears in the cycle after its byte is accepted.
//   Throughput: one byte per cycle unless stalled; the parser updates its state
//   in the cycle of acceptance and the single output register holds the result.
//   Stall: while a result waits in the output register and out_ready is low,
//   in_ready drops; when out_ready is high a new byte is taken in the same
//   cycle that the waiting result leaves.
//   Reset: rst (synchronous) returns the parser to the header phase, clears
//   captured fields, sets start_byte to START_RESET, empties output register.

module payload_frame_deframer #(
  parameter logic [7:0] START_RESET = pfd_pkg::START_BYTE_RESET
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  record_kind,
  output logic [7:0]  payload_byte,
  output logic [15:0] payload_index,
  output logic [15:0] frame_size,
  output logic [15:0] destination,
  output logic [15:0] origin,
  output logic [15:0] transaction_id,
  output logic [15:0] message_type,
  output logic [15:0] crc_value,
  output logic        last
);
  import pfd_pkg::*;

  logic [7:0] start_byte;
  logic       step;
  result_t    res;
  result_t    out_q;

  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  // Hold the expected start byte
  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= START_RESET;
    end else if (cfg_we) begin
      start_byte <= cfg_wdata;
    end
  end

  pfd_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .rx_byte    (rx_byte),
    .start_byte (start_byte),
    .res        (res)
  );

  // Output register: load on a beat with a result, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= res.valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.valid) begin
      out_q <= res;
    end
  end

  assign record_kind    = out_q.kind;
  assign payload_byte   = out_q.payload_byte;
  assign payload_index  = out_q.payload_index;
  assign frame_size     = out_q.frame_size;
  assign destination    = out_q.destination;
  assign origin         = out_q.origin;
  assign transaction_id = out_q.transaction_id;
  assign message_type   = out_q.message_type;
  assign crc_value      = out_q.crc_value;
  assign last           = out_q.last;

endmodule
